// ===== rtl/core/wspc_pkg.sv =====
// Shared types, constants and the control store of the wheel speed PID controller.
// Used by wspc_div and wheel_speed_pid_controller; depends on nothing.
package wspc_pkg;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_AW-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MAX_RPM      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_RPM_SCALE    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_CMD_TIMEOUT  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_PUB_PERIOD   = 3'd6;

  localparam logic [15:0] GAIN_P_RST      = 16'd1638;
  localparam logic [15:0] GAIN_I_RST      = 16'd0;
  localparam logic [15:0] GAIN_D_RST      = 16'd4096;
  localparam logic [15:0] MAX_RPM_RST     = 16'd1241;
  localparam logic [15:0] RPM_SCALE_RST   = 16'd27711;
  localparam logic [31:0] CMD_TIMEOUT_RST = 32'd600000;
  localparam logic [31:0] PUB_PERIOD_RST  = 32'd100000;

  // item kinds
  localparam logic [1:0] FUNC_ENC  = 2'd0;
  localparam logic [1:0] FUNC_CMD  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  // arithmetic
  localparam logic [13:0] ENC_K    = 14'd15625;
  localparam longint      PID_LIM  = 64'sd137438953472;
  localparam logic [7:0]  PWM_FULL = 8'd255;
  localparam int MUL_W = 33;
  localparam int ACC_W = 58;
  localparam int PID_W = 39;
  localparam int NUM_W = 49;

  // serial divider
  localparam int DIV_NW = 62;
  localparam int DIV_DW = 34;
  localparam int DIV_QW = 24;
  localparam int DIV_CW = $clog2(DIV_QW + 1);

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              ovf;
    logic [DIV_QW-1:0] quot;
  } div_stat_t;

  // microcode
  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_ENC_PREP, OP_ENC_MUL, OP_ENC_DIV, OP_ENC_SPEED, OP_CMD,
    OP_ERR, OP_SUM, OP_PID_D, OP_PID_IL, OP_PID_IH, OP_PID_SH, OP_PID_CLAMP,
    OP_NUM, OP_ABS, OP_PWM_DIV, OP_PWM_SET, OP_PUB, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT, C_JUMP, C_DTZ, C_BUSY, C_DISPATCH, C_OUT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_word_t;

  localparam upc_t UPC_IDLE     = 5'd0;
  localparam upc_t UPC_ENC      = 5'd1;
  localparam upc_t UPC_ENC_MUL  = 5'd2;
  localparam upc_t UPC_ENC_DIV  = 5'd3;
  localparam upc_t UPC_ENC_WAIT = 5'd4;
  localparam upc_t UPC_ENC_SPD  = 5'd5;
  localparam upc_t UPC_CMD      = 5'd6;
  localparam upc_t UPC_TICK     = 5'd7;
  localparam upc_t UPC_SUM      = 5'd8;
  localparam upc_t UPC_PID_D    = 5'd9;
  localparam upc_t UPC_PID_IL   = 5'd10;
  localparam upc_t UPC_PID_IH   = 5'd11;
  localparam upc_t UPC_PID_SH   = 5'd12;
  localparam upc_t UPC_CLAMP    = 5'd13;
  localparam upc_t UPC_NUM      = 5'd14;
  localparam upc_t UPC_ABS      = 5'd15;
  localparam upc_t UPC_PWM_DIV  = 5'd16;
  localparam upc_t UPC_PWM_WAIT = 5'd17;
  localparam upc_t UPC_PWM_SET  = 5'd18;
  localparam upc_t UPC_PUB      = 5'd19;
  localparam upc_t UPC_FIN      = 5'd20;

  function automatic ctrl_word_t ucode_rom(upc_t a);
    ctrl_word_t w;
    case (a)
      UPC_IDLE:     w = '{OP_NOP,       C_DISPATCH, UPC_IDLE};
      UPC_ENC:      w = '{OP_ENC_PREP,  C_NEXT,     UPC_IDLE};
      UPC_ENC_MUL:  w = '{OP_ENC_MUL,   C_DTZ,      UPC_FIN};
      UPC_ENC_DIV:  w = '{OP_ENC_DIV,   C_NEXT,     UPC_IDLE};
      UPC_ENC_WAIT: w = '{OP_NOP,       C_BUSY,     UPC_ENC_WAIT};
      UPC_ENC_SPD:  w = '{OP_ENC_SPEED, C_JUMP,     UPC_FIN};
      UPC_CMD:      w = '{OP_CMD,       C_JUMP,     UPC_FIN};
      UPC_TICK:     w = '{OP_ERR,       C_NEXT,     UPC_IDLE};
      UPC_SUM:      w = '{OP_SUM,       C_NEXT,     UPC_IDLE};
      UPC_PID_D:    w = '{OP_PID_D,     C_NEXT,     UPC_IDLE};
      UPC_PID_IL:   w = '{OP_PID_IL,    C_NEXT,     UPC_IDLE};
      UPC_PID_IH:   w = '{OP_PID_IH,    C_NEXT,     UPC_IDLE};
      UPC_PID_SH:   w = '{OP_PID_SH,    C_NEXT,     UPC_IDLE};
      UPC_CLAMP:    w = '{OP_PID_CLAMP, C_NEXT,     UPC_IDLE};
      UPC_NUM:      w = '{OP_NUM,       C_NEXT,     UPC_IDLE};
      UPC_ABS:      w = '{OP_ABS,       C_NEXT,     UPC_IDLE};
      UPC_PWM_DIV:  w = '{OP_PWM_DIV,   C_NEXT,     UPC_IDLE};
      UPC_PWM_WAIT: w = '{OP_NOP,       C_BUSY,     UPC_PWM_WAIT};
      UPC_PWM_SET:  w = '{OP_PWM_SET,   C_NEXT,     UPC_IDLE};
      UPC_PUB:      w = '{OP_PUB,       C_NEXT,     UPC_IDLE};
      UPC_FIN:      w = '{OP_EMIT,      C_OUT,      UPC_IDLE};
      default:      w = '{OP_NOP,       C_JUMP,     UPC_IDLE};
    endcase
    return w;
  endfunction

  function automatic upc_t func_entry(logic [1:0] f);
    upc_t e;
    case (f)
      FUNC_ENC:  e = UPC_ENC;
      FUNC_CMD:  e = UPC_CMD;
      FUNC_TICK: e = UPC_TICK;
      default:   e = UPC_FIN;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/core/wspc_div.sv =====
// Restoring serial divider, one quotient bit per cycle, with early overflow detection.
// Depends on wspc_pkg for widths and the request and status structs.
module wspc_div import wspc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  div_req_t  req,
  output div_stat_t stat
);

  logic              busy_r;
  logic              ovf_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_QW-1:0] low_r;
  logic [DIV_QW-1:0] quot_r;
  logic [DIV_CW-1:0] cnt_r;

  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;
  logic              ovf_start;

  assign ovf_start = req.num[DIV_NW-1:DIV_QW] >= {{(DIV_NW-DIV_QW-DIV_DW){1'b0}}, req.den};
  assign trial     = {rem_r, low_r[DIV_QW-1]};
  assign diff      = trial - {1'b0, den_r};
  assign ge        = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= !ovf_start;
    end else if (busy_r && cnt_r == DIV_CW'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ovf_r  <= ovf_start;
      rem_r  <= req.num[DIV_QW+DIV_DW-1:DIV_QW];
      low_r  <= req.num[DIV_QW-1:0];
      den_r  <= req.den;
      quot_r <= '0;
      cnt_r  <= DIV_CW'(DIV_QW);
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quot_r <= {quot_r[DIV_QW-2:0], ge};
      low_r  <= {low_r[DIV_QW-2:0], 1'b0};
      cnt_r  <= cnt_r - DIV_CW'(1);
    end
  end

  assign stat.busy = busy_r;
  assign stat.ovf  = ovf_r;
  assign stat.quot = quot_r;

endmodule

// ===== rtl/core/wheel_speed_pid_controller.sv =====
// Wheel speed PID controller: microcoded sequencer over a shared multiplier and divider.
// Depends on wspc_pkg and wspc_div.
//
//   channel  direction  payload
//   in_*     input      tuser: func; tdata: timestamp_us, encoder_ticks, target_rpm
//   out_*    output     tuser: pwm_valid, timed_out; tdata: pwm, measured_rpm
//   cfg_*    input      register write: index, data (no read-back)
//
// Each item runs a microprogram: a control tick and an encoder sample each use the 24-step
// serial divider, which skips its steps on quotient overflow; a command does not divide.
// An encoder sample with no elapsed time skips the division and goes to the output step.
// Reset (rst_n low, synchronous) loads the register defaults and clears the control state.
// A new item is taken while the previous result waits in the output register;
// the program holds at its last step while that register stays full.
module wheel_speed_pid_controller import wspc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [87:0]       in_tdata,   // timestamp_us, encoder_ticks, target_rpm
  input  logic [1:0]        in_tuser,   // func
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,  // pwm, measured_rpm, zero fill
  output logic [1:0]        out_tuser,  // pwm_valid, timed_out
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam logic signed [ACC_W-1:0] PID_HI = ACC_W'(PID_LIM);
  localparam logic signed [ACC_W-1:0] PID_LO = -PID_HI;

  // configuration
  logic [15:0] gain_p_r, gain_i_r, gain_d_r, max_rpm_r, rpm_scale_r;
  logic [31:0] cmd_timeout_r, pub_period_r;

  // architectural state
  logic [31:0]        last_ticks_r, last_sample_r, last_cmd_r, next_pub_r;
  logic signed [23:0] current_speed_r, wanted_speed_r;
  logic signed [39:0] error_sum_r;
  logic signed [24:0] last_error_r;
  logic signed [8:0]  drive_level_r;

  // sequencer and flags
  upc_t       pc_r, pc_nxt;
  ctrl_word_t cw;
  logic       valid_r, tout_r;
  logic       out_tvalid_r;
  logic [39:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  // datapath temporaries
  logic [31:0]             now_r, ticks_r;
  logic [23:0]             target_r;
  logic [31:0]             dt_r;
  logic [NUM_W-2:0]        mag_r;
  logic                    neg_r;
  logic signed [24:0]      err_r;
  logic signed [25:0]      d_r;
  logic signed [2*MUL_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [PID_W-1:0] pid_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  div_req_t  div_req;
  div_stat_t div_stat;

  logic        in_acc, out_free;
  logic [15:0] mr_eff;
  logic [31:0] delta, mag_enc;
  logic [40:0] sum_ext;
  logic signed [ACC_W-1:0] pid_clamped;
  logic signed [NUM_W-1:0] num_c;
  logic [NUM_W-1:0]        abs_num;
  logic [23:0]             speed_c;
  logic [7:0]              pwm_mag;
  logic [31:0]             pub_diff, cmd_age;
  logic                    emit;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (pc_r == UPC_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;
  assign cw        = ucode_rom(pc_r);
  assign mr_eff    = (max_rpm_r == 16'd0) ? 16'd1 : max_rpm_r;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  wspc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat)
  );

  always_comb begin
    case (cw.cond)
      C_NEXT:     pc_nxt = pc_r + upc_t'(1);
      C_JUMP:     pc_nxt = cw.target;
      C_DTZ:      pc_nxt = (dt_r == 32'd0) ? cw.target : pc_r + upc_t'(1);
      C_BUSY:     pc_nxt = div_stat.busy ? cw.target : pc_r + upc_t'(1);
      C_DISPATCH: pc_nxt = in_acc ? func_entry(in_tuser) : pc_r;
      C_OUT:      pc_nxt = out_free ? cw.target : pc_r;
      default:    pc_nxt = UPC_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cw.op)
      OP_ENC_PREP: begin
        mul_a = {17'd0, rpm_scale_r};
        mul_b = {19'd0, ENC_K};
      end
      OP_ENC_MUL: begin
        mul_a = {1'b0, mag_r[31:0]};
        mul_b = {3'd0, prod_r[29:0]};
      end
      OP_SUM: begin
        mul_a = {17'd0, gain_p_r};
        mul_b = {{8{err_r[24]}}, err_r};
      end
      OP_PID_D: begin
        mul_a = {17'd0, gain_d_r};
        mul_b = {{7{d_r[25]}}, d_r};
      end
      OP_PID_IL: begin
        mul_a = {17'd0, gain_i_r};
        mul_b = {13'd0, error_sum_r[19:0]};
      end
      OP_PID_IH: begin
        mul_a = {17'd0, gain_i_r};
        mul_b = {{13{error_sum_r[39]}}, error_sum_r[39:20]};
      end
      OP_PID_CLAMP: begin
        mul_a = {17'd0, mr_eff};
        mul_b = {{24{drive_level_r[8]}}, drive_level_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = prod_r[DIV_NW-1:0];
    div_req.den   = {dt_r, 2'b00};
    case (cw.op)
      OP_ENC_DIV: div_req.start = 1'b1;
      OP_PWM_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = {{(DIV_NW-NUM_W+21){1'b0}}, mag_r[NUM_W-2:20]};
        div_req.den   = {{(DIV_DW-16){1'b0}}, mr_eff};
      end
      default: div_req.start = 1'b0;
    endcase
  end

  assign delta    = ticks_r - last_ticks_r;
  assign mag_enc  = delta[31] ? 32'd0 - delta : delta;
  assign sum_ext  = {error_sum_r[39], error_sum_r} + {{16{err_r[24]}}, err_r};
  assign pid_clamped = (acc_r > PID_HI) ? PID_HI : ((acc_r < PID_LO) ? PID_LO : acc_r);
  assign num_c    = {{3{prod_r[25]}}, prod_r[25:0], 20'd0}
                  + {{2{pid_r[PID_W-1]}}, pid_r, 8'd0}
                  - {{(NUM_W-PID_W){pid_r[PID_W-1]}}, pid_r};
  assign abs_num  = acc_r[NUM_W-1] ? NUM_W'(0) - acc_r[NUM_W-1:0] : acc_r[NUM_W-1:0];
  assign pwm_mag  = (div_stat.ovf || (|div_stat.quot[DIV_QW-1:8])) ? PWM_FULL
                                                                   : div_stat.quot[7:0];
  assign pub_diff = now_r - next_pub_r;
  assign cmd_age  = now_r - last_cmd_r;
  assign emit     = !pub_diff[31] && (pub_diff != 32'd0);

  always_comb begin
    if (!neg_r) begin
      speed_c = (div_stat.ovf || div_stat.quot[23]) ? 24'h7FFFFF : div_stat.quot;
    end else if (div_stat.ovf || (div_stat.quot[23] && (|div_stat.quot[22:0]))) begin
      speed_c = 24'h800000;
    end else begin
      speed_c = 24'd0 - div_stat.quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= GAIN_P_RST;
      gain_i_r      <= GAIN_I_RST;
      gain_d_r      <= GAIN_D_RST;
      max_rpm_r     <= MAX_RPM_RST;
      rpm_scale_r   <= RPM_SCALE_RST;
      cmd_timeout_r <= CMD_TIMEOUT_RST;
      pub_period_r  <= PUB_PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_GAIN_P:      gain_p_r      <= cfg_wdata[15:0];
        REG_GAIN_I:      gain_i_r      <= cfg_wdata[15:0];
        REG_GAIN_D:      gain_d_r      <= cfg_wdata[15:0];
        REG_MAX_RPM:     max_rpm_r     <= cfg_wdata[15:0];
        REG_RPM_SCALE:   rpm_scale_r   <= cfg_wdata[15:0];
        REG_CMD_TIMEOUT: cmd_timeout_r <= cfg_wdata;
        REG_PUB_PERIOD:  pub_period_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r            <= UPC_IDLE;
      valid_r         <= 1'b0;
      tout_r          <= 1'b0;
      out_tvalid_r    <= 1'b0;
      last_ticks_r    <= '0;
      last_sample_r   <= '0;
      last_cmd_r      <= '0;
      next_pub_r      <= PUB_PERIOD_RST;
      current_speed_r <= '0;
      wanted_speed_r  <= '0;
      error_sum_r     <= '0;
      last_error_r    <= '0;
      drive_level_r   <= '0;
    end else begin
      pc_r <= pc_nxt;
      if (out_tvalid_r && out_tready && cw.op != OP_EMIT) begin
        out_tvalid_r <= 1'b0;
      end
      if (in_acc) begin
        valid_r <= 1'b0;
        tout_r  <= 1'b0;
      end
      case (cw.op)
        OP_ENC_PREP: begin
          last_ticks_r  <= ticks_r;
          last_sample_r <= now_r;
        end
        OP_ENC_SPEED: current_speed_r <= speed_c;
        OP_CMD: begin
          wanted_speed_r <= target_r;
          last_cmd_r     <= now_r;
        end
        OP_SUM: begin
          if (sum_ext[40] != sum_ext[39]) begin
            error_sum_r <= sum_ext[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
          end else begin
            error_sum_r <= sum_ext[39:0];
          end
          last_error_r <= err_r;
        end
        OP_PWM_SET: drive_level_r <= neg_r ? 9'd0 - {1'b0, pwm_mag} : {1'b0, pwm_mag};
        OP_PUB: begin
          if (emit) begin
            valid_r    <= 1'b1;
            next_pub_r <= now_r + pub_period_r;
            if (cmd_age > cmd_timeout_r) begin
              wanted_speed_r <= '0;
              drive_level_r  <= '0;
              tout_r         <= 1'b1;
            end
          end
        end
        OP_EMIT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
          end else begin
            out_tvalid_r <= out_tvalid_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r    <= in_tdata[31:0];
      ticks_r  <= in_tdata[63:32];
      target_r <= in_tdata[87:64];
    end
    case (cw.op)
      OP_ENC_PREP: begin
        dt_r   <= now_r - last_sample_r;
        neg_r  <= delta[31];
        mag_r  <= {{(NUM_W-33){1'b0}}, mag_enc};
        prod_r <= mul_p;
      end
      OP_ENC_MUL: prod_r <= mul_p;
      OP_ERR: err_r <= {wanted_speed_r[23], wanted_speed_r}
                     - {current_speed_r[23], current_speed_r};
      OP_SUM: begin
        d_r    <= {err_r[24], err_r} - {last_error_r[24], last_error_r};
        prod_r <= mul_p;
      end
      OP_PID_D: begin
        acc_r  <= prod_r[ACC_W-1:0];
        prod_r <= mul_p;
      end
      OP_PID_IL: begin
        acc_r  <= acc_r + prod_r[ACC_W-1:0];
        prod_r <= mul_p;
      end
      OP_PID_IH: begin
        acc_r  <= acc_r + prod_r[ACC_W-1:0];
        prod_r <= mul_p;
      end
      OP_PID_SH: acc_r <= acc_r + {prod_r[ACC_W-21:0], 20'd0};
      OP_PID_CLAMP: begin
        pid_r  <= pid_clamped[PID_W-1:0];
        prod_r <= mul_p;
      end
      OP_NUM: acc_r <= {{(ACC_W-NUM_W){num_c[NUM_W-1]}}, num_c};
      OP_ABS: begin
        neg_r <= acc_r[NUM_W-1];
        mag_r <= abs_num[NUM_W-2:0];
      end
      OP_EMIT: begin
        if (out_free) begin
          out_tdata_r <= {7'd0, current_speed_r, drive_level_r};
          out_tuser_r <= {tout_r, valid_r};
        end
      end
      default: ;
    endcase
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_tout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r[1]) |-> (out_tuser_r[0] && out_tdata_r[8:0] == 9'd0))
    else $error("timeout result without publish or with nonzero drive");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    drive_level_r != 9'h100)
    else $error("drive level out of range");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> pc_r != UPC_IDLE)
    else $error("accepted item did not start a program");

endmodule
